>>> rtl/core/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCW_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text console writer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text console writer check failed");

`endif

>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Cell layout, command codes, character codes and the result record.
// ----------------------------------------------------------------------------
package tcw_pkg;

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_MOVE  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	localparam logic [7:0] CHAR_BLANK     = 8'h20;
	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] ATTR_RESET     = 8'h07;
	localparam logic [3:0] FG_RESET       = 4'd7;
	localparam logic [3:0] BG_RESET       = 4'd0;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] attr;
	} cell_t;

	typedef logic [6:0]  ocol_t;
	typedef logic [4:0]  orow_t;
	typedef logic [10:0] olin_t;

	typedef struct packed {
		ocol_t      cursor_col;
		orow_t      cursor_row;
		olin_t      cursor_linear;
		logic [7:0] read_char;
		logic [7:0] read_attr;
		logic       scrolled;
	} res_t;

endpackage

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console: put, move, clear and read commands over a screen
// store held in one synchronous memory, with one result per command.
// ----------------------------------------------------------------------------
// Commands are taken one at a time; the single write port of the cell memory
// sets the timing. A clear blanks every cell; a put that scrolls moves the
// screen up one cell a cycle, then blanks the bottom row. A read of a cell
// off screen does not read the memory. After reset a clearing pass over all
// COLUMNS*ROWS cells (2000 at 80x25) fills the screen with light-grey-on-black
// spaces; in_ready stays low until it ends, while configuration writes are
// taken at any time. The result sits in an output register, so the next
// command is taken while the previous result waits for out_ready.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  ch,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_linear,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr,
	output logic        scrolled
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	logic [3:0]           fg_q;
	logic [3:0]           bg_q;
	logic                 out_valid_q;
	tcw_pkg::res_t        res_q;
	logic                 out_free;
	logic                 done;
	tcw_pkg::res_t        res;

	logic                 mem_we;
	logic [ADDR_W-1:0]    mem_waddr;
	tcw_pkg::cell_t       mem_wdata;
	logic                 mem_re;
	logic [ADDR_W-1:0]    mem_raddr;
	tcw_pkg::cell_t       mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::FG_RESET;
			bg_q <= tcw_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcw_pkg::CFG_FG: fg_q <= cfg_data;
				tcw_pkg::CFG_BG: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	tcw_engine #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.ch        (ch),
		.col       (col),
		.row       (row),
		.attr      ({bg_q, fg_q}),
		.out_free  (out_free),
		.done      (done),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcw_cell_ram #(
		.DEPTH  (CELL_COUNT),
		.ADDR_W (ADDR_W)
	) u_cell_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_valid     = out_valid_q;
	assign cursor_col    = res_q.cursor_col;
	assign cursor_row    = res_q.cursor_row;
	assign cursor_linear = res_q.cursor_linear;
	assign read_char     = res_q.read_char;
	assign read_attr     = res_q.read_attr;
	assign scrolled      = res_q.scrolled;

endmodule

>>> rtl/core/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// Text console cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  tcw_pkg::cell_t      wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output tcw_pkg::cell_t      rdata
);

	tcw_pkg::cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/tcw_engine.sv
// ----------------------------------------------------------------------------
// Text console command sequencer
// Keeps the cursor, decodes commands and drives the cell memory for puts,
// reads, clears, scrolls and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tcw_engine #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [7:0]                        ch,
	input  logic [7:0]                        col,
	input  logic [7:0]                        row,
	input  logic [7:0]                        attr,
	input  logic                              out_free,
	output logic                              done,
	output tcw_pkg::res_t                     res,
	output logic                              mem_we,
	output logic [$clog2(COLUMNS*ROWS)-1:0]   mem_waddr,
	output tcw_pkg::cell_t                    mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(COLUMNS*ROWS)-1:0]   mem_raddr,
	input  tcw_pkg::cell_t                    mem_rdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_PUT,
		S_CALC,
		S_RDWAIT,
		S_SCROLL,
		S_BLANK
	} state_t;

	state_t              state_q, state_n;
	logic [ADDR_W-1:0]   ptr_q, ptr_n;
	logic [COL_W-1:0]    col_q, col_n;
	logic [ROW_W-1:0]    row_q, row_n;
	logic [ADDR_W-1:0]   lin_q, lin_n;
	logic                scroll_q, scroll_n;
	logic                wpend_s1, wpend_n;
	logic [ADDR_W-1:0]   waddr_s1;

	tcw_pkg::mode_t      mode_q;
	logic [7:0]          ch_q;
	logic [7:0]          x_q;
	logic [7:0]          y_q;

	tcw_pkg::cell_t      blank_cell;

	// put-character decode
	logic                put_we;
	logic [ADDR_W-1:0]   put_addr;
	logic [7:0]          put_code;
	logic                put_scroll;
	logic [COL_W-1:0]    pc_col;
	logic [ROW_W-1:0]    pc_row;
	logic [ADDR_W-1:0]   pc_lin;

	// move / read address
	logic [COL_W-1:0]    x_cl;
	logic [ROW_W-1:0]    y_cl;
	logic [ADDR_W-1:0]   mv_lin;
	logic                in_range;

	logic [7:0]          rd_char;
	logic [7:0]          rd_attr;
	logic                res_scrolled;

	assign blank_cell = '{ch: tcw_pkg::CHAR_BLANK, attr: attr};

	always_comb begin
		put_we     = 1'b0;
		put_addr   = lin_q;
		put_code   = tcw_pkg::CHAR_BLANK;
		put_scroll = 1'b0;
		pc_col     = col_q;
		pc_row     = row_q;
		pc_lin     = lin_q;
		if (ch_q == tcw_pkg::CHAR_BACKSPACE) begin
			// step back, wrap to the end of the previous row, stay at top-left
			if (col_q != '0) begin
				pc_col = col_q - 1'b1;
				pc_lin = lin_q - 1'b1;
			end else if (row_q != '0) begin
				pc_row = row_q - 1'b1;
				pc_col = COL_LAST;
				pc_lin = lin_q - 1'b1;
			end
			put_we   = 1'b1;
			put_addr = pc_lin;
		end else if (ch_q == tcw_pkg::CHAR_NEWLINE) begin
			pc_col = '0;
			if (row_q == ROW_LAST) begin
				put_scroll = 1'b1;
			end else begin
				pc_row = row_q + 1'b1;
				pc_lin = lin_q - ADDR_W'(col_q) + COLS_A;
			end
		end else begin
			put_we   = 1'b1;
			put_code = ch_q;
			pc_lin   = lin_q + 1'b1;
			if (col_q == COL_LAST) begin
				pc_col = '0;
				if (row_q == ROW_LAST) begin
					put_scroll = 1'b1;
				end else begin
					pc_row = row_q + 1'b1;
				end
			end else begin
				pc_col = col_q + 1'b1;
			end
		end
		if (put_scroll) begin
			pc_row = ROW_LAST;
			pc_col = '0;
			pc_lin = SCROLL_END;
		end
	end

	always_comb begin
		x_cl     = (x_q >= COLUMNS) ? COL_LAST : COL_W'(x_q);
		y_cl     = (y_q >= ROWS) ? ROW_LAST : ROW_W'(y_q);
		mv_lin   = ADDR_W'(y_cl * COLUMNS) + ADDR_W'(x_cl);
		in_range = (x_q < COLUMNS) && (y_q < ROWS);
	end

	always_comb begin
		state_n      = state_q;
		ptr_n        = ptr_q;
		col_n        = col_q;
		row_n        = row_q;
		lin_n        = lin_q;
		scroll_n     = scroll_q;
		wpend_n      = 1'b0;
		in_ready     = 1'b0;
		done         = 1'b0;
		rd_char      = '0;
		rd_attr      = '0;
		res_scrolled = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = ptr_q;
		mem_wdata    = blank_cell;
		mem_re       = 1'b0;
		mem_raddr    = mv_lin;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '{ch: tcw_pkg::CHAR_BLANK, attr: tcw_pkg::ATTR_RESET};
				if (ptr_q == LAST_CELL) begin
					ptr_n   = '0;
					state_n = S_IDLE;
				end else begin
					ptr_n = ptr_q + 1'b1;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (tcw_pkg::mode_t'(mode))
						tcw_pkg::MODE_PUT: begin
							state_n = S_PUT;
						end
						tcw_pkg::MODE_CLEAR: begin
							col_n    = '0;
							row_n    = '0;
							lin_n    = '0;
							ptr_n    = '0;
							scroll_n = 1'b0;
							state_n  = S_BLANK;
						end
						tcw_pkg::MODE_MOVE, tcw_pkg::MODE_READ: begin
							state_n = S_CALC;
						end
						default: begin
							state_n = S_IDLE;
						end
					endcase
				end
			end
			S_PUT: begin
				mem_waddr = put_addr;
				mem_wdata = '{ch: put_code, attr: attr};
				if (put_scroll) begin
					// the write and cursor move land now, the result after the scroll
					mem_we   = put_we;
					col_n    = pc_col;
					row_n    = pc_row;
					lin_n    = pc_lin;
					ptr_n    = '0;
					scroll_n = 1'b1;
					state_n  = S_SCROLL;
				end else if (out_free) begin
					mem_we  = put_we;
					col_n   = pc_col;
					row_n   = pc_row;
					lin_n   = pc_lin;
					done    = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_CALC: begin
				if (mode_q == tcw_pkg::MODE_MOVE) begin
					if (out_free) begin
						col_n   = x_cl;
						row_n   = y_cl;
						lin_n   = mv_lin;
						done    = 1'b1;
						state_n = S_IDLE;
					end
				end else if (in_range) begin
					mem_re  = 1'b1;
					state_n = S_RDWAIT;
				end else if (out_free) begin
					done    = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_RDWAIT: begin
				rd_char = mem_rdata.ch;
				rd_attr = mem_rdata.attr;
				if (out_free) begin
					done    = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_SCROLL: begin
				// reads run one row ahead of the writes, so no entry is read after
				// it has been overwritten
				mem_waddr = waddr_s1;
				mem_wdata = mem_rdata;
				mem_we    = wpend_s1;
				if (ptr_q != SCROLL_END) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + COLS_A;
					wpend_n   = 1'b1;
					ptr_n     = ptr_q + 1'b1;
				end else begin
					state_n = S_BLANK;
				end
			end
			S_BLANK: begin
				mem_we       = 1'b1;
				res_scrolled = scroll_q;
				if (ptr_q == LAST_CELL) begin
					// the last cell is rewritten with a blank while stalled
					if (out_free) begin
						done     = 1'b1;
						scroll_n = 1'b0;
						state_n  = S_IDLE;
					end
				end else begin
					ptr_n = ptr_q + 1'b1;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.cursor_col    = tcw_pkg::ocol_t'(col_n);
		res.cursor_row    = tcw_pkg::orow_t'(row_n);
		res.cursor_linear = tcw_pkg::olin_t'(lin_n);
		res.read_char     = rd_char;
		res.read_attr     = rd_attr;
		res.scrolled      = res_scrolled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			ptr_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			lin_q    <= '0;
			scroll_q <= 1'b0;
			wpend_s1 <= 1'b0;
		end else begin
			state_q  <= state_n;
			ptr_q    <= ptr_n;
			col_q    <= col_n;
			row_q    <= row_n;
			lin_q    <= lin_n;
			scroll_q <= scroll_n;
			wpend_s1 <= wpend_n;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= ptr_q;
		if (in_valid && in_ready) begin
			mode_q <= tcw_pkg::mode_t'(mode);
			ch_q   <= ch;
			x_q    <= col;
			y_q    <= row;
		end
	end

endmodule

>>> rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer port checker
// Watches the top-level ports for result hold, one-at-a-time command
// intake and cursor placement.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  cursor_col,
	input logic [4:0]  cursor_row,
	input logic [10:0] cursor_linear,
	input logic [7:0]  read_char,
	input logic [7:0]  read_attr,
	input logic        scrolled
);

	localparam logic [4:0] LAST_ROW_OUT = 5'(ROWS - 1);

	logic [39:0] res_bits;
	logic        scroll_home;

	assign res_bits    = {cursor_col, cursor_row, cursor_linear, read_char, read_attr, scrolled};
	assign scroll_home = (cursor_col == 7'd0) && (cursor_row == LAST_ROW_OUT) &&
		(read_char == 8'd0);

	// a waiting result holds until its transfer
	`TCW_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(res_bits))

	// one command in flight: no intake right after a transfer in
	`TCW_ASSERT_NEXT(a_single_command, in_valid && in_ready, !in_ready)

	`TCW_ASSERT_IMPL(a_cursor_on_screen, out_valid, (cursor_col < COLUMNS) && (cursor_row < ROWS))

	// a scroll leaves the cursor at the start of the bottom row
	`TCW_ASSERT_IMPL(a_scroll_home, out_valid && scrolled, scroll_home)

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);
